// ----- design/skbs_pkg.sv -----
// Shared types and constants for the sorted-key binary search block.
package skbs_pkg;

  localparam int unsigned IDX_W = 12;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned OFS_W = 32;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_PRESENT = 1'b1;

  typedef enum logic [1:0] {
    ST_WRITTEN    = 2'd0,
    ST_FOUND      = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_NOT_LOADED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_PROBE,
    S_COMPARE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    wr_en;
    logic    step;
    logic    finish;
    status_t fin_status;
  } skbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_lookup;
    logic present;
    logic range_open;
    logic key_eq;
  } skbs_stat_t;

endpackage

// ----- design/skbs_ram.sv -----
// Generic single-port-write, registered-read RAM.
module skbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/skbs_ctrl.sv -----
// Controller state machine that sequences writes and binary search probes.
module skbs_ctrl
  import skbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  skbs_stat_t stat,
  output skbs_cmd_t  cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.load       = 1'b0;
    cmd.wr_en      = 1'b0;
    cmd.step       = 1'b0;
    cmd.finish     = 1'b0;
    cmd.fin_status = ST_WRITTEN;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!stat.in_lookup) begin
            state_nxt = S_WRITE;
          end else if (!stat.present) begin
            // No table to search: answer at once and stay idle.
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_NOT_LOADED;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_en      = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_WRITTEN;
        state_nxt      = S_IDLE;
      end
      S_PROBE: begin
        // The read of the middle entry is issued in this cycle.
        if (stat.range_open) begin
          state_nxt = S_COMPARE;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end
      end
      S_COMPARE: begin
        if (stat.key_eq) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- design/skbs_dp.sv -----
// Datapath: configuration registers, key and offset tables, search bounds and result.
module skbs_dp
  import skbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_command,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [KEY_W-1:0]     in_search_key,
  input  logic [OFS_W-1:0]     in_entry_offset,
  input  skbs_cmd_t            cmd,
  output skbs_stat_t           stat,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [OFS_W-1:0]     out_found_offset
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IXCMP = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned CTCMP = (CW > CNT_W) ? CW : CNT_W;

  logic [CNT_W-1:0] entry_count_r;
  logic             table_present_r;

  logic [KEY_W-1:0] key_r;
  logic [OFS_W-1:0] offset_r;
  logic [AW-1:0]    waddr_r;
  logic             wr_ok_r;
  logic [CW-1:0]    low_r;
  logic [CW-1:0]    low_nxt;
  logic [CW-1:0]    hi_r;
  logic [CW-1:0]    hi_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [OFS_W-1:0] out_found_offset_r;

  logic [CW-1:0]    count_clamped;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [KEY_W-1:0] key_rdata;
  logic [OFS_W-1:0] ofs_rdata;
  logic             idx_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      table_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT:   entry_count_r   <= cfg_wdata[CNT_W-1:0];
        REG_TABLE_PRESENT: table_present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A count above the table depth searches the whole table.
  assign count_clamped = (CTCMP'(entry_count_r) > CTCMP'(TABLE_DEPTH)) ?
                         CW'(TABLE_DEPTH) : CW'(entry_count_r);
  assign idx_in_range  = (IXCMP'(in_entry_index) < IXCMP'(TABLE_DEPTH));

  // The upper bound is kept exclusive, so the range is empty when low equals it.
  assign mid_sum = (CW+1)'(low_r) + (CW+1)'(hi_r) - (CW+1)'(1);
  assign mid     = mid_sum[CW:1];

  always_comb begin
    low_nxt = low_r;
    hi_nxt  = hi_r;
    if (cmd.load) begin
      low_nxt = '0;
      hi_nxt  = count_clamped;
    end else if (cmd.step) begin
      if (key_rdata < key_r) begin
        low_nxt = mid + CW'(1);
      end else begin
        hi_nxt = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r <= low_nxt;
    hi_r  <= hi_nxt;
    if (cmd.load) begin
      key_r    <= in_search_key;
      offset_r <= in_entry_offset;
      waddr_r  <= AW'(in_entry_index);
      wr_ok_r  <= idx_in_range;
    end
  end

  skbs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (cmd.wr_en && wr_ok_r),
    .waddr(waddr_r),
    .wdata(key_r),
    .raddr(AW'(mid)),
    .rdata(key_rdata)
  );

  skbs_ram #(
    .WIDTH(OFS_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ofs_ram (
    .clk  (clk),
    .we   (cmd.wr_en && wr_ok_r),
    .waddr(waddr_r),
    .wdata(offset_r),
    .raddr(AW'(mid)),
    .rdata(ofs_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_status_r       <= cmd.fin_status;
      out_found_offset_r <= (cmd.fin_status == ST_FOUND) ? ofs_rdata : '0;
    end
  end

  assign stat.in_lookup  = (in_command == CMD_LOOKUP);
  assign stat.present    = table_present_r;
  assign stat.range_open = (low_r < hi_r);
  assign stat.key_eq     = (key_rdata == key_r);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_offset = out_found_offset_r;

endmodule

// ----- design/sorted_key_binary_search.sv -----
// Top level of the sorted-key binary search block.
// An item is taken when start is high and busy is low; its single result appears on
// out_status and out_found_offset for one cycle with out_valid high, and must be taken
// then. A write item passes through the write state before its registered result. A
// lookup runs binary search probes, each a registered read of the key and offset RAMs
// followed by a compare. A lookup with the table marked not loaded answers from the
// idle state without a probe. The block handles one item at a time. Configuration
// writes take effect at once and are meant for idle periods only.
module sorted_key_binary_search
  import skbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [KEY_W-1:0]     in_search_key,
  input  logic [OFS_W-1:0]     in_entry_offset,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [OFS_W-1:0]     out_found_offset
);

  skbs_cmd_t  cmd;
  skbs_stat_t stat;

  skbs_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  skbs_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_entry_index  (in_entry_index),
    .in_search_key   (in_search_key),
    .in_entry_offset (in_entry_offset),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_offset(out_found_offset)
  );

endmodule

// ----- test/skbs_result_checker.sv -----
// Result checker for the sorted-key binary search block: predicts each answer and compares.
`timescale 1ns / 1ps
module skbs_result_checker
  import skbs_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_command,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [KEY_W-1:0]     in_search_key,
  input  logic [OFS_W-1:0]     in_entry_offset,
  input  logic                 out_valid,
  input  logic [1:0]           out_status,
  input  logic [OFS_W-1:0]     out_found_offset,
  output int                   mismatches,
  output int                   pending,
  output int                   checked
);

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] offset;
  } answer_t;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [OFS_W-1:0] ofs_mem [DEPTH];
  logic [CNT_W-1:0] entry_count;
  logic             table_present;
  answer_t          expected_answers [$];

  initial begin
    mismatches = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < 30) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Binary search over the entries below the count, with closed bounds.
  function automatic answer_t search_table(logic [KEY_W-1:0] key);
    int n;
    int lo;
    int hi;
    int mid;
    answer_t res;
    res.status = ST_NOT_FOUND;
    res.offset = '0;
    n = int'(entry_count);
    if (n > DEPTH) begin
      n = DEPTH;
    end
    lo = 0;
    hi = n - 1;
    if (!table_present) begin
      res.status = ST_NOT_LOADED;
    end else begin
      while (lo <= hi && res.status == ST_NOT_FOUND) begin
        mid = (lo + hi) / 2;
        if (key_mem[mid] == key) begin
          res.status = ST_FOUND;
          res.offset = ofs_mem[mid];
        end else if (key_mem[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      entry_count = '0;
      table_present = 1'b0;
      expected_answers.delete();
    end else begin
      // A result can only belong to an item accepted at an earlier edge.
      if (out_valid === 1'b1) begin
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("result with no item outstanding, status %0d", out_status));
        end else begin
          want = expected_answers.pop_front();
          checked++;
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status: expected %0d, got %0d", want.status, out_status));
          end
          if (out_found_offset !== want.offset) begin
            report_mismatch($sformatf("found_offset: expected %h, got %h",
                                      want.offset, out_found_offset));
          end
        end
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE) begin
          if (in_entry_index < DEPTH) begin
            key_mem[in_entry_index] = in_search_key;
            ofs_mem[in_entry_index] = in_entry_offset;
          end
          want.status = ST_WRITTEN;
          want.offset = '0;
        end else begin
          want = search_table(in_search_key);
        end
        expected_answers.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ENTRY_COUNT: begin
            entry_count = cfg_wdata[CNT_W-1:0];
          end
          REG_TABLE_PRESENT: begin
            table_present = cfg_wdata[0];
          end
          default: ;
        endcase
      end
    end
    pending = expected_answers.size();
  end

endmodule

// ----- test/tb_sorted_key_binary_search.sv -----
// Testbench top for the sorted-key binary search block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_sorted_key_binary_search;
  import skbs_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_FROM  = 1600;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 start;
  logic                 busy;
  logic                 in_command;
  logic [IDX_W-1:0]     in_entry_index;
  logic [KEY_W-1:0]     in_search_key;
  logic [OFS_W-1:0]     in_entry_offset;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [OFS_W-1:0]     out_found_offset;

  int mismatches;
  int pending;
  int checked;

  // What the stimulus side believes the block's entries hold, or will be written with.
  logic [KEY_W-1:0] shadow_key [DEPTH];
  logic [OFS_W-1:0] shadow_ofs [DEPTH];
  bit               shadow_set [DEPTH];

  int cur_count;
  bit cur_present;
  bit gaps_on;
  int n_items;
  int n_lookups;
  int n_writes;
  int n_settings;
  int stall_cycles = 0;

  always #10 clk = ~clk;

  sorted_key_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_search_key    (in_search_key),
    .in_entry_offset  (in_entry_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found_offset (out_found_offset)
  );

  skbs_result_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_search_key    (in_search_key),
    .in_entry_offset  (in_entry_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found_offset (out_found_offset),
    .mismatches       (mismatches),
    .pending          (pending),
    .checked          (checked)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item or result moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Entered and left just after a falling edge; start stays high when items follow back to back.
  task automatic send_item(logic cmd, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
                           logic [OFS_W-1:0] ofs);
    start <= 1'b1;
    in_command <= cmd;
    in_entry_index <= idx;
    in_search_key <= key;
    in_entry_offset <= ofs;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    n_items++;
    if (cmd == CMD_WRITE) begin
      shadow_key[idx] = key;
      shadow_ofs[idx] = ofs;
      shadow_set[idx] = 1'b1;
      n_writes++;
    end else begin
      n_lookups++;
    end
    if (gaps_on && n_items < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_ENTRY_COUNT) begin
      cur_count = int'(val);
    end else begin
      cur_present = val[0];
    end
  endtask

  task automatic configure(int count, bit present);
    logic [CFG_W-1:0] flag;
    flag = CFG_W'($urandom);
    flag[0] = present;
    drain();
    set_reg(REG_ENTRY_COUNT, count[CFG_W-1:0]);
    set_reg(REG_TABLE_PRESENT, flag);
    n_settings++;
  endtask

  // A search may probe any entry on its path, so each unwritten one is written first.
  task automatic lookup(logic [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = (cur_count > DEPTH ? DEPTH : cur_count) - 1;
    while (cur_present && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!shadow_set[mid]) begin
        send_item(CMD_WRITE, mid[IDX_W-1:0], shadow_key[mid], shadow_ofs[mid]);
      end
      if (shadow_key[mid] == key) begin
        lo = hi + 1;
      end else if (shadow_key[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    send_item(CMD_LOOKUP, IDX_W'($urandom), key, $urandom);
  endtask

  // Lays out the intended entry contents; nothing is written until a search path needs it.
  task automatic plan_entries(int n, bit sorted, bit pin_ends);
    logic [KEY_W-1:0] k;
    int width;
    k = pin_ends ? '0 : ({$urandom, $urandom} >> $urandom_range(1, 63));
    width = $urandom_range(1, 50);
    for (int i = 0; i < n; i++) begin
      shadow_set[i] = 1'b0;
      shadow_ofs[i] = $urandom;
      if (sorted) begin
        shadow_key[i] = k;
        // Now and then two neighbors share a key.
        if ($urandom_range(0, 15) != 0) begin
          k = k + ({$urandom, $urandom} >> (64 - width));
        end
      end else begin
        shadow_key[i] = {$urandom, $urandom};
      end
    end
    if (pin_ends && n > 0) begin
      shadow_key[n-1] = '1;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int n);
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    if (n > 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: k = shadow_key[$urandom_range(0, n - 1)];
        4: k = shadow_key[$urandom_range(0, n - 1)] + 1;
        5: k = shadow_key[$urandom_range(0, n - 1)] - 1;
        6: k = $urandom_range(0, 1) ? '0 : '1;
        default: ;
      endcase
    end
    return k;
  endfunction

  initial begin
    int n;
    int span;
    int idx;
    bit sorted;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_command = CMD_WRITE;
    in_entry_index = '0;
    in_search_key = '0;
    in_entry_offset = '0;
    cur_count = 0;
    cur_present = 1'b0;
    gaps_on = 1'b1;
    n_items = 0;
    n_lookups = 0;
    n_writes = 0;
    n_settings = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: not loaded, writes while not loaded, empty table, edge keys and offsets.
    lookup('0);
    lookup('1);
    send_item(CMD_WRITE, '0, '0, '1);
    send_item(CMD_WRITE, '1, '1, '0);
    send_item(CMD_WRITE, 12'd1, 64'd5, 32'hA5A5_5A5A);
    configure(0, 1'b1);
    lookup('0);
    configure(1, 1'b1);
    lookup('0);
    lookup(64'd1);
    configure(2, 1'b1);
    lookup(64'd5);
    lookup(64'd3);
    lookup('1);
    configure(2, 1'b0);
    lookup(64'd5);
    send_item(CMD_WRITE, 12'd2, 64'd9, '1);

    // Random phases; the first two use the full depth and a count beyond it.
    for (int phase = 0; n_items < ITEM_TARGET; phase++) begin
      if (phase == 0) begin
        n = DEPTH;
      end else if (phase == 1) begin
        n = 8191;
      end else begin
        case ($urandom_range(0, 19))
          0: n = DEPTH;
          1: n = $urandom_range(DEPTH + 1, 8191);
          2, 3, 4: n = $urandom_range(65, 600);
          default: n = $urandom_range(0, 64);
        endcase
      end
      configure(n, phase < 2 || $urandom_range(0, 5) != 0);
      gaps_on = $urandom_range(0, 2) != 0;
      sorted = phase < 2 || $urandom_range(0, 4) != 0;
      span = n > DEPTH ? DEPTH : n;
      plan_entries(span, sorted, $urandom_range(0, 3) == 0);
      for (int j = int'($urandom_range(20, 60)); j > 0 && n_items < ITEM_TARGET; j--) begin
        if ($urandom_range(0, 3) != 0) begin
          lookup(pick_key(span));
        end else begin
          // Stray writes: half keep the planned key, half break the ordering.
          idx = $urandom_range(0, DEPTH - 1);
          send_item(CMD_WRITE, idx[IDX_W-1:0],
                    $urandom_range(0, 1) ? shadow_key[idx] : {$urandom, $urandom}, $urandom);
        end
        if ($urandom_range(0, 40) == 0) begin
          drain();
        end
      end
    end

    gaps_on = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d results from %0d items: %0d lookups and %0d entry writes,",
             checked, n_items, n_lookups, n_writes);
    $display("over %0d register settings incl. empty, full-depth and over-depth counts.",
             n_settings);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
